@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks of the solver.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/qrs_pkg.sv @@
// ---------------------------------------------------------------------------
// qrs_pkg
// Widths, case codes and item types of the quadratic root solver.
// ---------------------------------------------------------------------------
package qrs_pkg;

    // Field widths.
    localparam int COEF_BITS = 16;
    localparam int FRAC_BITS = 16;
    localparam int OUT_BITS  = 40;

    // Internal widths derived from the field widths.
    localparam int DISC_BITS = 2 * COEF_BITS + 2;             // signed discriminant
    localparam int MAG_BITS  = 2 * COEF_BITS + 1;             // |discriminant|
    localparam int ROOT_BITS = (MAG_BITS + 1) / 2 + FRAC_BITS; // fixed-point root
    localparam int XS_BITS   = 2 * ROOT_BITS;                 // radicand shifter
    localparam int NB_BITS   = COEF_BITS + FRAC_BITS + 1;     // -b or -c scaled
    localparam int DEN_BITS  = COEF_BITS + 1;                 // 2a or b
    localparam int NUM_BITS  = ROOT_BITS + 2;                 // signed numerator
    localparam int QUO_BITS  = NUM_BITS - 1;                  // quotient magnitude

    // Result case codes.
    typedef enum logic [2:0] {
        CASE_TWO_REAL = 3'd0,
        CASE_DOUBLE   = 3'd1,
        CASE_COMPLEX  = 3'd2,
        CASE_LINEAR   = 3'd3,
        CASE_NONE     = 3'd4,
        CASE_ALL      = 3'd5
    } t_case;

    // One input item.
    typedef struct packed {
        logic signed [COEF_BITS-1:0] coef_a;
        logic signed [COEF_BITS-1:0] coef_b;
        logic signed [COEF_BITS-1:0] coef_c;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [2:0]                 case_code;
        logic signed [OUT_BITS-1:0] first_value;
        logic signed [OUT_BITS-1:0] second_value;
    } t_out_item;

    // Context that rides along the square root stages.
    typedef struct packed {
        t_case                      code;
        logic signed [NB_BITS-1:0]  nb;
        logic signed [DEN_BITS-1:0] den;
    } t_sq_ctx;

    // Context that rides along the divider stages.
    typedef struct packed {
        t_case               code;
        logic                q1neg;
        logic                q2neg;
        logic [DEN_BITS-1:0] dv;
    } t_dv_ctx;

endpackage

@@ src/quadratic_root_solver_unit.sv @@
// Throughput: one item per cycle while the skid entry is empty; one digit stage per square root and quotient bit.
// The sqrt chain (ROOT_BITS stages) and divider chain (QUO_BITS stages) set the depth.
// A two-entry output register and skid let input flow while a result waits.
// Reset is synchronous, active low, and clears every valid bit; no data is reset.
// ---------------------------------------------------------------------------
// quadratic_root_solver_unit
// Pipelined solver of a*x^2+b*x+c=0 giving case code and two Q23.16 values.
// ---------------------------------------------------------------------------
module quadratic_root_solver_unit
    import qrs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    localparam int RW = ROOT_BITS;
    localparam int QW = QUO_BITS;

    // Pipeline advance: the whole chain moves unless the skid entry is full.
    logic w_en;
    logic w_out_free;

    logic r_ov;
    logic r_skid_v;
    t_out_item r_out;
    t_out_item r_skid;

    assign w_en       = !r_skid_v;
    assign w_out_free = !r_ov || !i_stall;
    assign o_stall    = r_skid_v;
    assign o_valid    = r_ov;
    assign o_item     = r_out;

    // Stage 1: input register.
    logic     r_s1_v;
    t_in_item r_s1_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_item <= i_item;
        end
    end

    // Stage 2: products b*b and a*c, scaled numerator and divisor.
    logic                          r_s2_v;
    logic signed [2*COEF_BITS-1:0] r_s2_bb;
    logic signed [2*COEF_BITS-1:0] r_s2_ac;
    logic                          r_s2_azero;
    logic                          r_s2_bzero;
    logic                          r_s2_czero;
    logic signed [NB_BITS-1:0]     r_s2_nb;
    logic signed [DEN_BITS-1:0]    r_s2_den;

    logic signed [NB_BITS-1:0]  n_s2_nb;
    logic signed [DEN_BITS-1:0] n_s2_den;
    logic signed [NB_BITS-1:0]  w_sel_ext;
    logic                       w_azero;

    always_comb begin
        w_azero = (r_s1_item.coef_a == '0);
        // For the linear case the first numerator is -c and the divisor is b.
        if (w_azero) begin
            w_sel_ext = $signed({{(FRAC_BITS + 1){r_s1_item.coef_c[COEF_BITS-1]}},
                                 r_s1_item.coef_c});
            n_s2_den  = $signed({r_s1_item.coef_b[COEF_BITS-1], r_s1_item.coef_b});
        end else begin
            w_sel_ext = $signed({{(FRAC_BITS + 1){r_s1_item.coef_b[COEF_BITS-1]}},
                                 r_s1_item.coef_b});
            n_s2_den  = $signed({r_s1_item.coef_a, 1'b0});
        end
        n_s2_nb = -(w_sel_ext <<< FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_bb    <= (2 * COEF_BITS)'(r_s1_item.coef_b)
                        * (2 * COEF_BITS)'(r_s1_item.coef_b);
            r_s2_ac    <= (2 * COEF_BITS)'(r_s1_item.coef_a)
                        * (2 * COEF_BITS)'(r_s1_item.coef_c);
            r_s2_azero <= w_azero;
            r_s2_bzero <= (r_s1_item.coef_b == '0);
            r_s2_czero <= (r_s1_item.coef_c == '0);
            r_s2_nb    <= n_s2_nb;
            r_s2_den   <= n_s2_den;
        end
    end

    // Square root stage registers; index 0 holds the discriminant stage.
    logic                 r_sq_v    [0:RW];
    logic [RW-1:0]        r_sq_root [0:RW];
    logic [RW:0]          r_sq_rem  [0:RW];
    logic [XS_BITS-1:0]   r_sq_x    [0:RW];
    t_sq_ctx              r_sq_ctx  [0:RW];

    // Stage 3: discriminant, its magnitude and the case code.
    logic signed [DISC_BITS-1:0] w_d;
    logic signed [DISC_BITS-1:0] w_dabs;
    logic [MAG_BITS-1:0]         w_mag;
    t_case                       n_code;
    t_sq_ctx                     n_sq0_ctx;

    always_comb begin
        w_d = $signed({{2{r_s2_bb[2*COEF_BITS-1]}}, r_s2_bb})
            - ($signed({{2{r_s2_ac[2*COEF_BITS-1]}}, r_s2_ac}) <<< 2);
        w_dabs = w_d[DISC_BITS-1] ? -w_d : w_d;
        w_mag  = w_dabs[MAG_BITS-1:0];
        if (r_s2_azero) begin
            if (!r_s2_bzero) begin
                n_code = CASE_LINEAR;
            end else if (!r_s2_czero) begin
                n_code = CASE_NONE;
            end else begin
                n_code = CASE_ALL;
            end
        end else if (w_d == '0) begin
            n_code = CASE_DOUBLE;
        end else if (w_d[DISC_BITS-1]) begin
            n_code = CASE_COMPLEX;
        end else begin
            n_code = CASE_TWO_REAL;
        end
        n_sq0_ctx.code = n_code;
        n_sq0_ctx.nb   = r_s2_nb;
        n_sq0_ctx.den  = r_s2_den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (w_en) begin
            r_sq_v[0] <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_root[0] <= '0;
            r_sq_rem[0]  <= '0;
            r_sq_x[0]    <= XS_BITS'(w_mag) << (2 * FRAC_BITS);
            r_sq_ctx[0]  <= n_sq0_ctx;
        end
    end

    // Restoring square root: one result bit per stage.
    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        logic [RW+1:0] w_t;
        logic [RW+1:0] w_trial;
        logic [RW+1:0] w_diff;
        logic          w_ge;
        logic [RW:0]   n_rem;

        always_comb begin
            w_t     = {r_sq_rem[k][RW-1:0], r_sq_x[k][XS_BITS-1 -: 2]};
            w_trial = {r_sq_root[k], 2'b01};
            w_diff  = w_t - w_trial;
            w_ge    = (w_t >= w_trial);
            n_rem   = w_ge ? w_diff[RW:0] : w_t[RW:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else if (w_en) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_root[k+1] <= {r_sq_root[k][RW-2:0], w_ge};
                r_sq_rem[k+1]  <= n_rem;
                r_sq_x[k+1]    <= {r_sq_x[k][XS_BITS-3:0], 2'b00};
                r_sq_ctx[k+1]  <= r_sq_ctx[k];
            end
        end
    end

    // Numerator stage: combine the scaled -b (or -c in the linear case) with the root.
    logic                       r_nm_v;
    logic signed [NUM_BITS-1:0] r_nm_n1;
    logic signed [NUM_BITS-1:0] r_nm_n2;
    t_sq_ctx                    r_nm_ctx;

    logic signed [NUM_BITS-1:0] w_nbx;
    logic signed [NUM_BITS-1:0] w_sx;
    logic signed [NUM_BITS-1:0] n_nm_n1;
    logic signed [NUM_BITS-1:0] n_nm_n2;

    always_comb begin
        w_nbx = $signed({{(NUM_BITS - NB_BITS){r_sq_ctx[RW].nb[NB_BITS-1]}},
                         r_sq_ctx[RW].nb});
        w_sx  = $signed({2'b00, r_sq_root[RW]});
        case (r_sq_ctx[RW].code)
            CASE_TWO_REAL: begin
                n_nm_n1 = w_nbx + w_sx;
                n_nm_n2 = w_nbx - w_sx;
            end
            CASE_COMPLEX: begin
                n_nm_n1 = w_nbx;
                n_nm_n2 = w_sx;
            end
            default: begin
                n_nm_n1 = w_nbx;
                n_nm_n2 = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nm_v <= 1'b0;
        end else if (w_en) begin
            r_nm_v <= r_sq_v[RW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nm_n1  <= n_nm_n1;
            r_nm_n2  <= n_nm_n2;
            r_nm_ctx <= r_sq_ctx[RW];
        end
    end

    // Divider stage registers; index 0 holds the magnitudes and signs.
    logic                r_dv_v   [0:QW];
    logic [QW-1:0]       r_dv_q1  [0:QW];
    logic [QW-1:0]       r_dv_q2  [0:QW];
    logic [DEN_BITS-1:0] r_dv_r1  [0:QW];
    logic [DEN_BITS-1:0] r_dv_r2  [0:QW];
    t_dv_ctx             r_dv_ctx [0:QW];

    // Sign and magnitude split: quotients truncate toward zero.
    logic signed [NUM_BITS-1:0] w_a1;
    logic signed [NUM_BITS-1:0] w_a2;
    logic signed [DEN_BITS-1:0] w_aden;
    logic                       w_dneg;
    t_dv_ctx                    n_dv0_ctx;

    always_comb begin
        w_dneg = r_nm_ctx.den[DEN_BITS-1];
        w_a1   = r_nm_n1[NUM_BITS-1] ? -r_nm_n1 : r_nm_n1;
        w_a2   = r_nm_n2[NUM_BITS-1] ? -r_nm_n2 : r_nm_n2;
        w_aden = w_dneg ? -r_nm_ctx.den : r_nm_ctx.den;
        n_dv0_ctx.code  = r_nm_ctx.code;
        n_dv0_ctx.q1neg = r_nm_n1[NUM_BITS-1] ^ w_dneg;
        n_dv0_ctx.q2neg = r_nm_n2[NUM_BITS-1] ^ w_dneg;
        n_dv0_ctx.dv    = w_aden;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (w_en) begin
            r_dv_v[0] <= r_nm_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_q1[0]  <= w_a1[QW-1:0];
            r_dv_q2[0]  <= w_a2[QW-1:0];
            r_dv_r1[0]  <= '0;
            r_dv_r2[0]  <= '0;
            r_dv_ctx[0] <= n_dv0_ctx;
        end
    end

    // Restoring division: numerator bits shift out the top and quotient
    // bits shift in at the bottom, one per stage, for both values at once.
    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [DEN_BITS:0]   w_t1;
        logic [DEN_BITS:0]   w_t2;
        logic [DEN_BITS:0]   w_dvx;
        logic [DEN_BITS:0]   w_d1;
        logic [DEN_BITS:0]   w_d2;
        logic                w_ge1;
        logic                w_ge2;
        logic [DEN_BITS-1:0] n_r1;
        logic [DEN_BITS-1:0] n_r2;

        always_comb begin
            w_dvx = {1'b0, r_dv_ctx[k].dv};
            w_t1  = {r_dv_r1[k], r_dv_q1[k][QW-1]};
            w_t2  = {r_dv_r2[k], r_dv_q2[k][QW-1]};
            w_d1  = w_t1 - w_dvx;
            w_d2  = w_t2 - w_dvx;
            w_ge1 = (w_t1 >= w_dvx);
            w_ge2 = (w_t2 >= w_dvx);
            n_r1  = w_ge1 ? w_d1[DEN_BITS-1:0] : w_t1[DEN_BITS-1:0];
            n_r2  = w_ge2 ? w_d2[DEN_BITS-1:0] : w_t2[DEN_BITS-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else if (w_en) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_q1[k+1]  <= {r_dv_q1[k][QW-2:0], w_ge1};
                r_dv_q2[k+1]  <= {r_dv_q2[k][QW-2:0], w_ge2};
                r_dv_r1[k+1]  <= n_r1;
                r_dv_r2[k+1]  <= n_r2;
                r_dv_ctx[k+1] <= r_dv_ctx[k];
            end
        end
    end

    // Final sign, widening and masking of unused values.
    logic signed [OUT_BITS-1:0] w_v1;
    logic signed [OUT_BITS-1:0] w_v2;
    t_out_item                  w_fin;

    always_comb begin
        w_v1 = $signed({{(OUT_BITS - QW){1'b0}}, r_dv_q1[QW]});
        w_v2 = $signed({{(OUT_BITS - QW){1'b0}}, r_dv_q2[QW]});
        w_fin.case_code    = r_dv_ctx[QW].code;
        w_fin.first_value  = r_dv_ctx[QW].q1neg ? -w_v1 : w_v1;
        w_fin.second_value = r_dv_ctx[QW].q2neg ? -w_v2 : w_v2;
        case (r_dv_ctx[QW].code)
            CASE_TWO_REAL, CASE_COMPLEX: begin
            end
            CASE_DOUBLE, CASE_LINEAR: begin
                w_fin.second_value = '0;
            end
            default: begin
                w_fin.first_value  = '0;
                w_fin.second_value = '0;
            end
        endcase
    end

    // Output register with one skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_en) begin
            if (w_out_free) begin
                r_ov <= r_dv_v[QW];
            end else if (r_dv_v[QW]) begin
                r_skid_v <= 1'b1;
            end
        end else if (w_out_free) begin
            r_ov     <= 1'b1;
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_out_free) begin
                r_out <= w_fin;
            end else begin
                r_skid <= w_fin;
            end
        end else if (w_out_free) begin
            r_out <= r_skid;
        end
    end

endmodule

@@ src/qrs_checker.sv @@
// ---------------------------------------------------------------------------
// qrs_checker
// Port-level checks of the quadratic root solver, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qrs_checker
    import qrs_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_stall,
    input logic      i_out_valid,
    input logic      i_out_stall,
    input t_out_item i_out_item
);

    // A stalled result item holds its value.
    `QRS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_item), "stalled result item changed")

    // The input side stalls only while a result item is on show.
    `QRS_ASSERT_IMP(a_stall_has_out, i_clk, i_rst_n, i_in_stall, i_out_valid, "input stalled with no result item waiting")

    // Cases with at most one value leave the second value at zero.
    `QRS_ASSERT_IMP(a_second_zero, i_clk, i_rst_n, i_out_valid && (i_out_item.case_code == CASE_DOUBLE || i_out_item.case_code == CASE_LINEAR || i_out_item.case_code == CASE_NONE || i_out_item.case_code == CASE_ALL), i_out_item.second_value == '0, "second value not zero")

    // Cases without a root leave the first value at zero.
    `QRS_ASSERT_IMP(a_first_zero, i_clk, i_rst_n, i_out_valid && (i_out_item.case_code == CASE_NONE || i_out_item.case_code == CASE_ALL), i_out_item.first_value == '0, "first value not zero")

endmodule

bind quadratic_root_solver_unit qrs_checker u_qrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_stall  (o_stall),
    .i_out_valid (o_valid),
    .i_out_stall (i_stall),
    .i_out_item  (o_item)
);
